@@ src/b58_pkg.sv @@
// ----------------------------------------------------------------------------
// b58_pkg
// Shared constants, types and the alphabet lookup of the base58 encoder.
// ----------------------------------------------------------------------------
package b58_pkg;

	localparam int BYTE_W          = 8;
	localparam int SYM_W           = 7;
	localparam int DIGIT_W         = 6;
	localparam int RADIX           = 58;
	localparam int MAX_RESULTS     = 45;
	localparam int SENT_W          = $clog2(MAX_RESULTS + 1);
	localparam int MAX_BYTES_DEF   = 32;
	localparam int DIGIT_DEPTH_DEF = 45;

	// carry never exceeds 256, so carry + 256 * digit stays below 2**14
	localparam int CARRY_W     = 9;
	localparam int SUM_W       = 14;
	localparam int RECIP_W     = 15;
	localparam int RECIP_SHIFT = 20;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SHIFT) + RADIX - 1) / RADIX);

	localparam logic [SYM_W-1:0] CHAR_ONE = 7'h31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_APPEND,
		ST_EMIT_ONES,
		ST_EMIT_RD,
		ST_EMIT_WR
	} b58_state_t;

	// digit to character of the bitcoin alphabet, out-of-range digits clamp to 'z'
	function automatic logic [SYM_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
		logic [SYM_W-1:0] dx;
		dx = SYM_W'(d);
		if (d < 6'd9) begin
			b58_char = dx + 7'h31;
		end else if (d < 6'd17) begin
			b58_char = dx - 7'd9 + 7'h41;
		end else if (d < 6'd22) begin
			b58_char = dx - 7'd17 + 7'h4a;
		end else if (d < 6'd33) begin
			b58_char = dx - 7'd22 + 7'h50;
		end else if (d < 6'd44) begin
			b58_char = dx - 7'd33 + 7'h61;
		end else if (d < 6'd58) begin
			b58_char = dx - 7'd44 + 7'h6d;
		end else begin
			b58_char = 7'h7a;
		end
	endfunction

endpackage

@@ src/b58_in_if.sv @@
// ----------------------------------------------------------------------------
// b58_in_if
// Message byte channel: valid, ready, byte and end-of-message flag.
// ----------------------------------------------------------------------------
interface b58_in_if import b58_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              final_byte;

	modport source(output valid, data_byte, final_byte, input ready);
	modport sink(input valid, data_byte, final_byte, output ready);
endinterface

@@ src/b58_out_if.sv @@
// ----------------------------------------------------------------------------
// b58_out_if
// Encoded character channel: valid, ready, character and flags.
// ----------------------------------------------------------------------------
interface b58_out_if import b58_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last_symbol;
	logic             too_long;

	modport source(output valid, symbol, last_symbol, too_long, input ready);
	modport sink(input valid, symbol, last_symbol, too_long, output ready);
endinterface

@@ src/b58_ram.sv @@
// ----------------------------------------------------------------------------
// b58_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module b58_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/b58_digit_unit.sv @@
// ----------------------------------------------------------------------------
// b58_digit_unit
// One carry step: (carry + 256 * digit) split into quotient and remainder by 58.
// ----------------------------------------------------------------------------
module b58_digit_unit import b58_pkg::*; (
	input  logic [CARRY_W-1:0] carry_in,
	input  logic [DIGIT_W-1:0] digit_in,
	output logic [CARRY_W-1:0] quo,
	output logic [DIGIT_W-1:0] rem
);

	localparam int PROD_W = SUM_W + RECIP_W;

	logic [SUM_W-1:0]  sum;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  back;

	assign sum  = SUM_W'(carry_in) + {digit_in, 8'h00};
	// reciprocal multiply is exact for every sum below 2**14
	assign prod = PROD_W'(sum) * PROD_W'(RECIP);
	assign quo  = prod[RECIP_SHIFT +: CARRY_W];
	assign back = SUM_W'(quo) * SUM_W'(RADIX);
	assign rem  = DIGIT_W'(sum - back);

endmodule

@@ src/base58_encoder_top.sv @@
// ----------------------------------------------------------------------------
// base58_encoder_top
// Base58 (bitcoin alphabet) encoder, one message byte per transaction.
// ----------------------------------------------------------------------------
// The message arrives a byte per transaction, most significant first, with
// final_byte on the last one. The digits of the number live in a RAM, least
// significant first; each byte is folded in by a read-modify-write walk over
// every stored digit, one digit per cycle, followed by an append step for each
// new top digit and a closing step. After the final byte the block sends one
// '1' per leading zero byte, then the digits from the top, each by a RAM read
// and then a load of the output register; a load waits while the output
// register still holds an unaccepted character. Bytes past MAX_BYTES are
// dropped and too_long is set on every character of that message. A new
// message may start while the last character still waits in the output
// register.
// ----------------------------------------------------------------------------
module base58_encoder_top import b58_pkg::*; #(
	parameter int MAX_BYTES   = MAX_BYTES_DEF,
	parameter int DIGIT_DEPTH = DIGIT_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	b58_in_if.sink    msg,
	b58_out_if.source sym
);

	localparam int CNT_W = $clog2(DIGIT_DEPTH + 1);
	localparam int IDX_W = $clog2(DIGIT_DEPTH);
	localparam int BT_W  = $clog2(MAX_BYTES + 1);

	b58_state_t state_q, state_d;

	logic [CARRY_W-1:0] carry_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   digit_count_q;
	logic [BT_W-1:0]    zpc_q;
	logic               in_zero_q;
	logic [BT_W-1:0]    bytes_taken_q;
	logic               overflowed_q;
	logic               fin_q;
	logic [SENT_W-1:0]  sent_q;
	logic               out_valid_q;
	logic [SYM_W-1:0]   symbol_q;
	logic               last_q;
	logic               too_long_q;

	logic               msg_take;
	logic               room;
	logic               slot_free;
	logic               can_append;
	logic [CNT_W-1:0]   idx_next;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [DIGIT_W-1:0] ram_rdata;
	logic [DIGIT_W-1:0] unit_digit;
	logic [CARRY_W-1:0] unit_quo;
	logic [DIGIT_W-1:0] unit_rem;
	logic               load;
	logic [SYM_W-1:0]   load_symbol;
	logic               load_last;
	logic               finish;

	assign msg.ready  = (state_q == ST_IDLE);
	assign msg_take   = msg.valid && msg.ready;
	assign room       = bytes_taken_q < BT_W'(MAX_BYTES);
	assign slot_free  = !out_valid_q || sym.ready;
	assign can_append = (carry_q != '0) && (digit_count_q < CNT_W'(DIGIT_DEPTH));
	assign idx_next   = idx_q + CNT_W'(1);
	assign unit_digit = (state_q == ST_WALK) ? ram_rdata : '0;

	b58_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(DIGIT_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(unit_rem),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	b58_digit_unit u_unit (
		.carry_in(carry_q),
		.digit_in(unit_digit),
		.quo     (unit_quo),
		.rem     (unit_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ram_we      = 1'b0;
		ram_waddr   = idx_q[IDX_W-1:0];
		ram_re      = 1'b0;
		ram_raddr   = '0;
		load        = 1'b0;
		load_symbol = CHAR_ONE;
		load_last   = 1'b0;
		finish      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (msg_take) begin
					if (room) begin
						if (digit_count_q != '0) begin
							ram_re  = 1'b1;
							state_d = ST_WALK;
						end else begin
							state_d = ST_APPEND;
						end
					end else if (msg.final_byte) begin
						state_d = ST_EMIT_ONES;
					end
				end
			end
			ST_WALK: begin
				ram_we = 1'b1;
				// next digit is read while this one is written back
				if (idx_next < digit_count_q) begin
					ram_re    = 1'b1;
					ram_raddr = idx_next[IDX_W-1:0];
				end else begin
					state_d = ST_APPEND;
				end
			end
			ST_APPEND: begin
				if (can_append) begin
					ram_we    = 1'b1;
					ram_waddr = digit_count_q[IDX_W-1:0];
				end else begin
					state_d = fin_q ? ST_EMIT_ONES : ST_IDLE;
				end
			end
			ST_EMIT_ONES: begin
				if (zpc_q == '0) begin
					state_d = ST_EMIT_RD;
				end else if (slot_free) begin
					load      = 1'b1;
					load_last = (sent_q == SENT_W'(MAX_RESULTS - 1)) ||
						((zpc_q == BT_W'(1)) && (digit_count_q == '0));
					if (load_last) begin
						finish  = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT_RD: begin
				ram_re    = 1'b1;
				ram_raddr = IDX_W'(digit_count_q - CNT_W'(1));
				state_d   = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				if (slot_free) begin
					load        = 1'b1;
					load_symbol = b58_char(ram_rdata);
					load_last   = (sent_q == SENT_W'(MAX_RESULTS - 1)) ||
						(digit_count_q == CNT_W'(1));
					finish      = load_last;
					state_d     = load_last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= '0;
			zpc_q         <= '0;
			in_zero_q     <= 1'b1;
			bytes_taken_q <= '0;
			overflowed_q  <= 1'b0;
			sent_q        <= '0;
			fin_q         <= 1'b0;
			idx_q         <= '0;
			carry_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (msg_take) begin
						fin_q <= msg.final_byte;
						if (room) begin
							carry_q       <= CARRY_W'(msg.data_byte);
							idx_q         <= '0;
							bytes_taken_q <= bytes_taken_q + BT_W'(1);
							if (in_zero_q && (msg.data_byte == '0)) begin
								zpc_q <= zpc_q + BT_W'(1);
							end else begin
								in_zero_q <= 1'b0;
							end
						end else begin
							overflowed_q <= 1'b1;
						end
					end
				end
				ST_WALK: begin
					carry_q <= unit_quo;
					idx_q   <= idx_next;
				end
				ST_APPEND: begin
					if (can_append) begin
						carry_q       <= unit_quo;
						digit_count_q <= digit_count_q + CNT_W'(1);
					end
				end
				ST_EMIT_ONES: begin
					if (load) begin
						zpc_q  <= zpc_q - BT_W'(1);
						sent_q <= sent_q + SENT_W'(1);
					end
				end
				ST_EMIT_WR: begin
					if (load) begin
						digit_count_q <= digit_count_q - CNT_W'(1);
						sent_q        <= sent_q + SENT_W'(1);
					end
				end
				default: begin
				end
			endcase
			// message done: back to an empty number
			if (finish) begin
				digit_count_q <= '0;
				zpc_q         <= '0;
				in_zero_q     <= 1'b1;
				bytes_taken_q <= '0;
				overflowed_q  <= 1'b0;
				sent_q        <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (sym.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			symbol_q   <= load_symbol;
			last_q     <= load_last;
			too_long_q <= overflowed_q;
		end
	end

	assign sym.valid       = out_valid_q;
	assign sym.symbol      = symbol_q;
	assign sym.last_symbol = last_q;
	assign sym.too_long    = too_long_q;

	// the walk only touches digits already held
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (idx_q < digit_count_q))
		else $error("digit walk beyond held digits");

	a_carry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WALK) || (state_q == ST_APPEND)) |-> (carry_q <= CARRY_W'(256)))
		else $error("carry exceeds its bound");

	a_digit_written: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (unit_rem < DIGIT_W'(RADIX)))
		else $error("stored digit not below the radix");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(digit_count_q <= CNT_W'(DIGIT_DEPTH)) && (sent_q < SENT_W'(MAX_RESULTS)))
		else $error("digit count or character count out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !sym.ready) |-> !load)
		else $error("output register overwritten while held");

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the base58 encoder against a behavioural model of the digit store.
// Messages are sent a byte per transaction. Every accepted byte is folded into
// a local copy of the base-58 number, and a final byte queues the characters
// the block must send. The tests cover single-byte messages, leading zero
// bytes, the length limit, a long output stall and random traffic. Both sides
// of the block insert random gaps.
// ----------------------------------------------------------------------------
module testbench import b58_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          ITEM_TARGET   = 330;
	localparam int          SETTLE_CYCLES = 64;
	localparam int          CYCLE_LIMIT   = 1000000;
	localparam int          HOLD_CYCLES   = 300;
	localparam logic [58*8-1:0] ALPHABET  =
		"123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last_symbol;
		logic             too_long;
	} encoded_char_t;

	logic clk;
	logic arst_n;

	b58_in_if  msg_if();
	b58_out_if sym_if();

	base58_encoder_top #(
		.MAX_BYTES   (MAX_BYTES_DEF),
		.DIGIT_DEPTH (DIGIT_DEPTH_DEF)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.sym    (sym_if)
	);

	// model of the number being encoded, least significant digit first
	logic [DIGIT_W-1:0] b58_digits [DIGIT_DEPTH_DEF];
	int unsigned        n_digits;
	int unsigned        n_leading_zeros;
	bit                 in_leading_zeros;
	int unsigned        n_bytes;
	bit                 bytes_dropped;

	encoded_char_t pending_chars[$];
	int unsigned   mismatches;
	int unsigned   items_sent;
	int unsigned   sink_hold_cycles;
	bit            no_gaps;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void clear_number();
		foreach (b58_digits[i])
			b58_digits[i] = '0;
		n_digits         = 0;
		n_leading_zeros  = 0;
		in_leading_zeros = 1'b1;
		n_bytes          = 0;
		bytes_dropped    = 1'b0;
	endfunction

	function automatic logic [SYM_W-1:0] digit_char(input int unsigned d);
		return SYM_W'(ALPHABET[(57 - d) * 8 +: 8]);
	endfunction

	// folds one byte into the number; on the final byte queues the characters
	function automatic void fold_byte(input logic [BYTE_W-1:0] b, input logic fin);
		int unsigned   carry;
		int unsigned   total;
		int unsigned   produced;
		int unsigned   d;
		encoded_char_t ch;
		if (n_bytes < MAX_BYTES_DEF) begin
			carry = b;
			for (int unsigned i = 0; i < n_digits; i++) begin
				carry         = carry + int'(b58_digits[i]) * 256;
				b58_digits[i] = DIGIT_W'(carry % RADIX);
				carry         = carry / RADIX;
			end
			while (carry > 0 && n_digits < DIGIT_DEPTH_DEF) begin
				b58_digits[n_digits] = DIGIT_W'(carry % RADIX);
				n_digits++;
				carry = carry / RADIX;
			end
			if (in_leading_zeros && b == '0)
				n_leading_zeros++;
			else
				in_leading_zeros = 1'b0;
			n_bytes++;
		end else begin
			bytes_dropped = 1'b1;
		end
		if (!fin)
			return;
		total    = n_leading_zeros + n_digits;
		if (total > MAX_RESULTS)
			total = MAX_RESULTS;
		produced = 0;
		for (int unsigned i = 0; i < n_leading_zeros && produced < total; i++) begin
			ch.symbol      = digit_char(0);
			ch.too_long    = bytes_dropped;
			ch.last_symbol = (produced + 1 == total);
			pending_chars.push_back(ch);
			produced++;
		end
		for (int unsigned i = n_digits; i > 0 && produced < total; i--) begin
			d = b58_digits[i - 1];
			if (d >= RADIX)
				d = RADIX - 1;
			ch.symbol      = digit_char(d);
			ch.too_long    = bytes_dropped;
			ch.last_symbol = (produced + 1 == total);
			pending_chars.push_back(ch);
			produced++;
		end
		clear_number();
	endfunction

	// output check first, then the input byte taken at the same edge
	always @(posedge clk) begin
		encoded_char_t want;
		if (arst_n && sym_if.valid && sym_if.ready) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected character, expected none, got %c (%h)",
					$time, sym_if.symbol, sym_if.symbol);
				mismatches++;
			end else begin
				want = pending_chars.pop_front();
				if (sym_if.symbol !== want.symbol) begin
					$display("%0t: symbol expected %c (%h), got %c (%h)", $time,
						want.symbol, want.symbol, sym_if.symbol, sym_if.symbol);
					mismatches++;
				end
				if (sym_if.last_symbol !== want.last_symbol) begin
					$display("%0t: last_symbol expected %b, got %b", $time,
						want.last_symbol, sym_if.last_symbol);
					mismatches++;
				end
				if (sym_if.too_long !== want.too_long) begin
					$display("%0t: too_long expected %b, got %b", $time,
						want.too_long, sym_if.too_long);
					mismatches++;
				end
			end
		end
		if (arst_n && msg_if.valid && msg_if.ready)
			fold_byte(msg_if.data_byte, msg_if.final_byte);
	end

	// character sink: random stall per transaction, plus an occasional long hold-off
	initial begin
		int unsigned stall;
		sym_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (sink_hold_cycles != 0) begin
				@(negedge clk) sym_if.ready <= 1'b0;
				repeat (sink_hold_cycles) @(negedge clk);
				sink_hold_cycles = 0;
			end
			stall = no_gaps ? 0 : $urandom_range(0, 6);
			repeat (stall) @(negedge clk) sym_if.ready <= 1'b0;
			@(negedge clk) sym_if.ready <= 1'b1;
			do @(posedge clk); while (!(sym_if.valid && sym_if.ready));
		end
	end

	initial begin
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("FAIL");
		$finish;
	end

	function automatic logic [BYTE_W-1:0] random_byte();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return BYTE_W'($urandom);
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			@(negedge clk);
			msg_if.valid      <= 1'b0;
			msg_if.data_byte  <= BYTE_W'($urandom);
			msg_if.final_byte <= 1'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		msg_if.valid      <= 1'b1;
		msg_if.data_byte  <= b;
		msg_if.final_byte <= fin;
		do @(posedge clk); while (!(msg_if.valid && msg_if.ready));
		items_sent++;
	endtask

	task automatic send_message(input logic [BYTE_W-1:0] bytes[$]);
		foreach (bytes[i])
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic wait_for_idle();
		@(negedge clk) msg_if.valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_single_byte_messages();
		send_message('{8'h00});
		send_message('{8'hff});
		send_message('{8'h01});
		send_message('{8'h39});
		send_message('{8'h3a});
		wait_for_idle();
	endtask

	task automatic test_leading_zeros();
		send_message('{8'h00, 8'h00, 8'h01});
		send_message('{8'h00, 8'h00, 8'h00});
		send_message('{8'h00, 8'h80, 8'h00, 8'h00});
		wait_for_idle();
	endtask

	task automatic test_length_limit();
		logic [BYTE_W-1:0] bytes[$];
		// largest number that fits in MAX_BYTES bytes: the most digits a message can give
		for (int i = 0; i < MAX_BYTES_DEF; i++)
			bytes.push_back(8'hff);
		send_message(bytes);
		// all zeros and one past the limit, final byte dropped
		bytes.delete();
		for (int i = 0; i <= MAX_BYTES_DEF; i++)
			bytes.push_back(8'h00);
		send_message(bytes);
		bytes.delete();
		for (int i = 0; i < MAX_BYTES_DEF + 3; i++)
			bytes.push_back(random_byte());
		send_message(bytes);
		wait_for_idle();
	endtask

	// sink stops for a long stretch while messages keep coming
	task automatic test_output_backpressure();
		int n;
		sink_hold_cycles = HOLD_CYCLES;
		for (int m = 0; m < 5; m++) begin
			n = $urandom_range(1, 4);
			for (int k = 0; k < n; k++)
				send_byte(random_byte(), k == n - 1);
		end
		wait_for_idle();
	endtask

	task automatic test_random_messages();
		int unsigned len;
		int unsigned zeros;
		int unsigned pick;
		while (items_sent < ITEM_TARGET) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			pick    = $urandom_range(0, 19);
			if (pick < 15)
				len = $urandom_range(1, 6);
			else if (pick < 19)
				len = $urandom_range(7, MAX_BYTES_DEF);
			else
				len = $urandom_range(MAX_BYTES_DEF + 1, MAX_BYTES_DEF + 6);
			zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
			for (int unsigned k = 0; k < len; k++)
				send_byte((k < zeros) ? 8'h00 : random_byte(), k == len - 1);
		end
		no_gaps = 1'b0;
		wait_for_idle();
	endtask

	initial begin
		arst_n            = 1'b0;
		msg_if.valid      = 1'b0;
		msg_if.data_byte  = '0;
		msg_if.final_byte = 1'b0;
		mismatches        = 0;
		items_sent        = 0;
		sink_hold_cycles  = 0;
		no_gaps           = 1'b0;
		clear_number();
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		test_single_byte_messages();
		test_leading_zeros();
		test_length_limit();
		test_output_backpressure();
		test_random_messages();

		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
